// ===== rtl/core/upx_pkg.sv =====
// Shared types and constants for the pixel replication upscaler.
`timescale 1ns / 1ps
`default_nettype none
package upx_pkg;

  localparam int unsigned PIX_W     = 24;
  localparam int unsigned SCALE_W   = 7;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned PAD_W     = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [SCALE_W-1:0] SCALE_MAX = 7'd100;
  localparam logic [DIM_W-1:0]   DIM_MAX   = 11'd2047;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EMIT = 1'b1
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_EMIT_EARLY = 2'd1,
    ST_LOAD_BUSY  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SCALE  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic              kind;
    logic [PIX_W-1:0]  pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]    pixel_out;
    logic [PAD_W-1:0]    pad_bytes;
    logic                row_end;
    logic                frame_end;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // Clamped limits as seen by the sequencer
  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [PAD_W-1:0]   pad;
  } lim_t;

  // Result fields that do not come from the line memory
  typedef struct packed {
    logic                is_pixel;
    logic [PAD_W-1:0]    pad_bytes;
    logic                row_end;
    logic                frame_end;
    logic [STATUS_W-1:0] status;
  } meta_t;

endpackage
`default_nettype wire

// ===== rtl/core/upx_line_mem.sv =====
// Line buffer memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module upx_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [upx_pkg::PIX_W-1:0]  wr_data,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [upx_pkg::PIX_W-1:0]  rd_data
);

  logic [upx_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/upx_cfg.sv =====
// APB register block: raw register file and clamped limits for the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module upx_cfg #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [upx_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [upx_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [upx_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                     pready,
  output upx_pkg::lim_t                            lim
);

  localparam logic [upx_pkg::DIM_W-1:0] W_CAP =
    (MAX_WIDTH > 2047) ? upx_pkg::DIM_MAX : upx_pkg::DIM_W'(MAX_WIDTH);
  localparam logic [upx_pkg::DIM_W-1:0] H_CAP =
    (MAX_HEIGHT > 2047) ? upx_pkg::DIM_MAX : upx_pkg::DIM_W'(MAX_HEIGHT);

  logic [upx_pkg::SCALE_W-1:0] scale_r;
  logic [upx_pkg::DIM_W-1:0]   width_r;
  logic [upx_pkg::DIM_W-1:0]   height_r;
  logic [upx_pkg::SCALE_W-1:0] eff_scale_r, eff_scale_nxt;
  logic [upx_pkg::DIM_W-1:0]   eff_width_r, eff_width_nxt;
  logic [upx_pkg::DIM_W-1:0]   eff_height_r, eff_height_nxt;
  logic                        wr_go;
  upx_pkg::reg_idx_t           idx;
  logic [3:0]                  pad_prod;

  assign pready = 1'b1;
  assign wr_go  = psel && penable && pwrite && pready;
  assign idx    = upx_pkg::reg_idx_t'(paddr[3:2]);

  always_comb begin
    eff_scale_nxt  = eff_scale_r;
    eff_width_nxt  = eff_width_r;
    eff_height_nxt = eff_height_r;
    if (wr_go) begin
      unique case (idx)
        upx_pkg::REG_SCALE: begin
          if (pwdata[6:0] == '0)                     eff_scale_nxt = 7'd1;
          else if (pwdata[6:0] > upx_pkg::SCALE_MAX) eff_scale_nxt = upx_pkg::SCALE_MAX;
          else                                       eff_scale_nxt = pwdata[6:0];
        end
        upx_pkg::REG_WIDTH: begin
          if (pwdata[10:0] == '0)        eff_width_nxt = 11'd1;
          else if (pwdata[10:0] > W_CAP) eff_width_nxt = W_CAP;
          else                           eff_width_nxt = pwdata[10:0];
        end
        upx_pkg::REG_HEIGHT: begin
          if (pwdata[10:0] == '0)        eff_height_nxt = 11'd1;
          else if (pwdata[10:0] > H_CAP) eff_height_nxt = H_CAP;
          else                           eff_height_nxt = pwdata[10:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r      <= 7'd1;
      width_r      <= 11'd1;
      height_r     <= 11'd1;
      eff_scale_r  <= 7'd1;
      eff_width_r  <= 11'd1;
      eff_height_r <= 11'd1;
    end else begin
      eff_scale_r  <= eff_scale_nxt;
      eff_width_r  <= eff_width_nxt;
      eff_height_r <= eff_height_nxt;
      if (wr_go) begin
        unique case (idx)
          upx_pkg::REG_SCALE:  scale_r  <= pwdata[6:0];
          upx_pkg::REG_WIDTH:  width_r  <= pwdata[10:0];
          upx_pkg::REG_HEIGHT: height_r <= pwdata[10:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      upx_pkg::REG_SCALE:  prdata = {25'd0, scale_r};
      upx_pkg::REG_WIDTH:  prdata = {21'd0, width_r};
      upx_pkg::REG_HEIGHT: prdata = {21'd0, height_r};
      default:             prdata = '0;
    endcase
  end

  // 3*w*s padding to 4 bytes reduces to (w*s) mod 4
  assign pad_prod   = eff_width_r[1:0] * eff_scale_r[1:0];
  assign lim.scale  = eff_scale_r;
  assign lim.width  = eff_width_r;
  assign lim.height = eff_height_r;
  assign lim.pad    = pad_prod[1:0];

endmodule
`default_nettype wire

// ===== rtl/core/upx_ctrl.sv =====
// Sequencer: fill and scan counters, line memory addressing, output register.
`timescale 1ns / 1ps
`default_nettype none
module upx_ctrl #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned AW         = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire upx_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output upx_pkg::meta_t                  meta,
  input  wire upx_pkg::lim_t              lim,
  output logic                            wr_en,
  output logic [AW-1:0]                   wr_addr,
  output logic [upx_pkg::PIX_W-1:0]       wr_data,
  output logic                            rd_en,
  output logic [AW-1:0]                   rd_addr
);

  localparam int unsigned FW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [FW-1:0]               fill_r, fill_nxt;
  logic [AW-1:0]               col_r, col_nxt;
  logic [upx_pkg::SCALE_W-1:0] across_r, across_nxt;
  logic [upx_pkg::SCALE_W-1:0] down_r, down_nxt;
  logic [RW-1:0]               row_r, row_nxt;
  logic                        emitting_r, emitting_nxt;
  logic                        out_valid_r, out_valid_nxt;
  upx_pkg::meta_t              meta_r, meta_nxt;

  logic        accept, is_emit;
  logic [FW:0] fill_inc;
  logic        last_copy, last_col, last_down, last_row;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_emit  = (in_data.kind == upx_pkg::KIND_EMIT);
  assign fill_inc = {1'b0, fill_r} + 1'b1;

  assign last_copy = ({1'b0, across_r} + 8'd1) >= {1'b0, lim.scale};
  assign last_down = ({1'b0, down_r} + 8'd1) >= {1'b0, lim.scale};
  assign last_col  = (32'(col_r) + 32'd1) >= 32'(lim.width);
  assign last_row  = (32'(row_r) + 32'd1) >= 32'(lim.height);

  // Load and emit never share a cycle, so a read always sees the last write
  assign wr_en   = accept && !is_emit && !emitting_r && (32'(fill_r) < 32'(MAX_WIDTH));
  assign wr_addr = fill_r[AW-1:0];
  assign wr_data = in_data.pixel_in;
  assign rd_en   = accept && is_emit && emitting_r;
  assign rd_addr = col_r;

  always_comb begin
    fill_nxt      = fill_r;
    col_nxt       = col_r;
    across_nxt    = across_r;
    down_nxt      = down_r;
    row_nxt       = row_r;
    emitting_nxt  = emitting_r;
    meta_nxt      = meta_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (accept) begin
      if (!is_emit) begin
        if (emitting_r) begin
          meta_nxt      = '{is_pixel: 1'b0, pad_bytes: '0, row_end: 1'b0,
                            frame_end: 1'b0, status: upx_pkg::ST_LOAD_BUSY};
          out_valid_nxt = 1'b1;
        end else begin
          fill_nxt = fill_inc[FW-1:0];
          if (32'(fill_inc) >= 32'(lim.width)) begin
            emitting_nxt = 1'b1;
            col_nxt      = '0;
            across_nxt   = '0;
            down_nxt     = '0;
          end
        end
      end else if (!emitting_r) begin
        meta_nxt      = '{is_pixel: 1'b0, pad_bytes: '0, row_end: 1'b0,
                          frame_end: 1'b0, status: upx_pkg::ST_EMIT_EARLY};
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt      = 1'b1;
        meta_nxt           = '0;
        meta_nxt.is_pixel  = 1'b1;
        meta_nxt.status    = upx_pkg::ST_OK;
        meta_nxt.row_end   = last_copy && last_col;
        if (!last_copy) begin
          across_nxt = across_r + 1'b1;
        end else if (!last_col) begin
          across_nxt = '0;
          col_nxt    = col_r + 1'b1;
        end else begin
          meta_nxt.pad_bytes = lim.pad;
          across_nxt         = '0;
          col_nxt            = '0;
          if (!last_down) begin
            down_nxt = down_r + 1'b1;
          end else begin
            down_nxt     = '0;
            emitting_nxt = 1'b0;
            fill_nxt     = '0;
            if (last_row) begin
              meta_nxt.frame_end = 1'b1;
              row_nxt            = '0;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      col_r       <= '0;
      across_r    <= '0;
      down_r      <= '0;
      row_r       <= '0;
      emitting_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      col_r       <= col_nxt;
      across_r    <= across_nxt;
      down_r      <= down_nxt;
      row_r       <= row_nxt;
      emitting_r  <= emitting_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meta_r <= meta_nxt;
  end

  assign out_valid = out_valid_r;
  assign meta      = meta_r;

endmodule
`default_nettype wire

// ===== rtl/core/pixel_replication_upscaler_unit.sv =====
// Top level of the pixel replication upscaler.
//
// Input channel (in_valid/in_ready/in_data): each transfer is a load of one
// input pixel or a request for the next enlarged pixel. Loads fill the line
// buffer; once a row of in_width pixels is in, emit requests return that row
// scale times across and scale times down, then loading resumes.
// Result channel (out_valid/out_ready/out_data): one result for every emit
// and for every load refused while emitting; accepted loads give none.
// A result is presented in the cycle after its item is accepted, with
// the pixel taken straight from the line memory's registered read port.
// Throughput: one item per cycle, set by the single read and single write
// port of the line memory (a load writes, an emit reads, never both at once).
// Receiver stall: the output register holds its result, and in_ready drops
// until it is taken; while the result is taken, a new item is accepted.
// Reset (rst_n low, synchronous) clears all counters to the loading phase
// and sets scale, in_width and in_height to 1. The line memory is not
// cleared; each entry read is loaded in the same row unless in_width grows.
// APB: registers scale, in_width, in_height at byte offsets 0, 4, 8.
`timescale 1ns / 1ps
`default_nettype none
module pixel_replication_upscaler_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire upx_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output upx_pkg::out_item_t                   out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [upx_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [upx_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [upx_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  upx_pkg::lim_t             lim;
  upx_pkg::meta_t            meta;
  logic                      wr_en, rd_en;
  logic [AW-1:0]             wr_addr, rd_addr;
  logic [upx_pkg::PIX_W-1:0] wr_data, rd_data;

  upx_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .lim     (lim)
  );

  upx_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .meta      (meta),
    .lim       (lim),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  upx_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Refused items carry a zero pixel
  assign out_data.pixel_out = meta.is_pixel ? rd_data : '0;
  assign out_data.pad_bytes = meta.pad_bytes;
  assign out_data.row_end   = meta.row_end;
  assign out_data.frame_end = meta.frame_end;
  assign out_data.status    = meta.status;

endmodule
`default_nettype wire

// ===== rtl/core/upx_checker.sv =====
// Port-level checks for the pixel replication upscaler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module upx_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire upx_pkg::out_item_t out_data,
  input wire logic               pready
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != upx_pkg::ST_OK) |->
      out_data.pixel_out == '0 && out_data.pad_bytes == '0 &&
      !out_data.row_end && !out_data.frame_end)
    else $error("refused item carries nonzero fields");

  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.row_end)
    else $error("frame end without row end");

  a_pad_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pad_bytes != '0) |-> out_data.row_end)
    else $error("padding off a row end");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind pixel_replication_upscaler_unit upx_checker u_upx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);
`default_nettype wire

// ===== tb/tb_pixel_replication_upscaler_unit.sv =====
// Self-checking testbench for the pixel replication upscaler top level.
`timescale 1ns / 1ps
module tb_pixel_replication_upscaler_unit;

  localparam int unsigned LINE_MAX        = 1024;
  localparam int unsigned ROWS_MAX        = 1024;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  // Longest legal quiet stretch is the hold-off plus one long gap on each side.
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned PRINT_LIMIT     = 50;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  upx_pkg::in_item_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  upx_pkg::out_item_t             out_data;
  logic                           psel      = 1'b0;
  logic                           penable   = 1'b0;
  logic                           pwrite    = 1'b0;
  logic [upx_pkg::APB_ADDR_W-1:0] paddr     = '0;
  logic [upx_pkg::APB_DATA_W-1:0] pwdata    = '0;
  logic [upx_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  // Local copy of the registers and the sequencer state
  logic [upx_pkg::SCALE_W-1:0] cfg_scale  = 1;
  logic [upx_pkg::DIM_W-1:0]   cfg_width  = 1;
  logic [upx_pkg::DIM_W-1:0]   cfg_height = 1;
  logic [upx_pkg::PIX_W-1:0]   line_mem [LINE_MAX];
  int unsigned                 fill_cnt   = 0;
  int unsigned                 col_idx    = 0;
  int unsigned                 across_cnt = 0;
  int unsigned                 down_cnt   = 0;
  int unsigned                 row_cnt    = 0;
  bit                          emit_phase = 1'b0;

  upx_pkg::out_item_t expected_pixels_q [$];
  int unsigned        mismatch_count = 0;
  bit                 idle_on        = 1'b1;
  bit                 hold_off_req   = 1'b0;

  pixel_replication_upscaler_unit #(
    .MAX_WIDTH (LINE_MAX),
    .MAX_HEIGHT(ROWS_MAX)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp_limit(input int unsigned v, input int unsigned top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  // Advance the local sequencer by one accepted transfer and queue its result.
  function automatic void replicate_pixel(input upx_pkg::in_item_t item);
    upx_pkg::out_item_t res;
    int unsigned        s;
    int unsigned        w;
    int unsigned        h;
    bit                 last_copy;
    bit                 last_col;
    res = '0;
    s = clamp_limit(cfg_scale, upx_pkg::SCALE_MAX);
    w = clamp_limit(cfg_width, LINE_MAX);
    h = clamp_limit(cfg_height, ROWS_MAX);
    if (item.kind == upx_pkg::KIND_LOAD) begin
      if (emit_phase) begin
        res.status = upx_pkg::ST_LOAD_BUSY;
        expected_pixels_q.push_back(res);
      end else begin
        if (fill_cnt < LINE_MAX) line_mem[fill_cnt] = item.pixel_in;
        fill_cnt++;
        if (fill_cnt >= w) begin
          emit_phase = 1'b1;
          col_idx    = 0;
          across_cnt = 0;
          down_cnt   = 0;
        end
      end
    end else if (!emit_phase) begin
      res.status = upx_pkg::ST_EMIT_EARLY;
      expected_pixels_q.push_back(res);
    end else begin
      res.pixel_out = line_mem[col_idx];
      last_copy = (across_cnt + 1 >= s);
      last_col  = (col_idx + 1 >= w);
      res.row_end = last_copy && last_col;
      if (!last_copy) begin
        across_cnt++;
      end else if (!last_col) begin
        across_cnt = 0;
        col_idx++;
      end else begin
        res.pad_bytes = 2'((4 - (w * s * 3) % 4) % 4);
        across_cnt = 0;
        col_idx    = 0;
        if (down_cnt + 1 < s) begin
          down_cnt++;
        end else begin
          down_cnt   = 0;
          emit_phase = 1'b0;
          fill_cnt   = 0;
          if (row_cnt + 1 >= h) begin
            res.frame_end = 1'b1;
            row_cnt = 0;
          end else begin
            row_cnt++;
          end
        end
      end
      res.status = upx_pkg::ST_OK;
      expected_pixels_q.push_back(res);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Mostly the transfer the sequencer wants next; noise_pct percent of the wrong kind.
  function automatic upx_pkg::in_item_t make_item(input int unsigned noise_pct);
    upx_pkg::in_item_t item;
    bit                well_formed;
    well_formed = ($urandom_range(0, 99) >= noise_pct);
    item.kind = (emit_phase == well_formed) ? upx_pkg::KIND_EMIT : upx_pkg::KIND_LOAD;
    case ($urandom_range(0, 7))
      0:       item.pixel_in = '0;
      1:       item.pixel_in = '1;
      default: item.pixel_in = upx_pkg::PIX_W'($urandom);
    endcase
    return item;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_item(input upx_pkg::in_item_t item);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    replicate_pixel(item);
  endtask

  task automatic send_kind(input upx_pkg::kind_t kind,
                           input logic [upx_pkg::PIX_W-1:0] pix);
    upx_pkg::in_item_t item;
    item.kind     = kind;
    item.pixel_in = pix;
    send_item(item);
  endtask

  // Wait until every queued result has arrived and the pipeline is empty.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input upx_pkg::reg_idx_t idx, input logic [31:0] value);
    drain_block();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      upx_pkg::REG_SCALE:  cfg_scale  = value[upx_pkg::SCALE_W-1:0];
      upx_pkg::REG_WIDTH:  cfg_width  = value[upx_pkg::DIM_W-1:0];
      upx_pkg::REG_HEIGHT: cfg_height = value[upx_pkg::DIM_W-1:0];
      default: ;
    endcase
  endtask

  // Finish the row being emitted so that in_width may grow afterwards.
  task automatic settle_row();
    if (emit_phase) begin
      write_reg(upx_pkg::REG_SCALE, 1);
      while (emit_phase) send_kind(upx_pkg::KIND_EMIT, upx_pkg::PIX_W'($urandom));
    end
  endtask

  task automatic run_random_phase(input int unsigned scale_val, width_val, height_val,
                                  n_items, noise_pct);
    settle_row();
    write_reg(upx_pkg::REG_SCALE, scale_val);
    write_reg(upx_pkg::REG_WIDTH, width_val);
    write_reg(upx_pkg::REG_HEIGHT, height_val);
    repeat (n_items) send_item(make_item(noise_pct));
  endtask

  // Registers at their reset values: one pixel, no enlargement, one row.
  task automatic test_reset_defaults();
    send_kind(upx_pkg::KIND_EMIT, 24'h000000);
    send_kind(upx_pkg::KIND_LOAD, 24'hFFFFFF);
    send_kind(upx_pkg::KIND_EMIT, 24'hFFFFFF);
  endtask

  // Early emit and refused load around a 2x2 row.
  task automatic test_phase_errors();
    write_reg(upx_pkg::REG_SCALE, 2);
    write_reg(upx_pkg::REG_WIDTH, 2);
    write_reg(upx_pkg::REG_HEIGHT, 2);
    send_kind(upx_pkg::KIND_LOAD, 24'h000000);
    send_kind(upx_pkg::KIND_EMIT, 24'h123456);
    send_kind(upx_pkg::KIND_LOAD, 24'hA5A5A5);
    send_kind(upx_pkg::KIND_LOAD, 24'h5A5A5A);
    repeat (8) send_kind(upx_pkg::KIND_EMIT, 24'hFFFFFF);
  endtask

  // Shrink scale, width, height while across and column counters sit past new limits.
  task automatic test_midframe_change();
    write_reg(upx_pkg::REG_SCALE, 3);
    write_reg(upx_pkg::REG_WIDTH, 3);
    write_reg(upx_pkg::REG_HEIGHT, 4);
    send_kind(upx_pkg::KIND_LOAD, 24'h123456);
    send_kind(upx_pkg::KIND_LOAD, 24'hFEDCBA);
    send_kind(upx_pkg::KIND_LOAD, 24'h00FF00);
    repeat (4) send_kind(upx_pkg::KIND_EMIT, 24'h000000);
    write_reg(upx_pkg::REG_SCALE, 1);
    send_kind(upx_pkg::KIND_EMIT, 24'h000000);
    write_reg(upx_pkg::REG_WIDTH, 2);
    write_reg(upx_pkg::REG_HEIGHT, 1);
    send_kind(upx_pkg::KIND_EMIT, 24'h000000);
  endtask

  // Hold the receiver off long enough that the input channel stalls.
  task automatic test_backpressure();
    settle_row();
    write_reg(upx_pkg::REG_SCALE, 2);
    write_reg(upx_pkg::REG_WIDTH, 4);
    write_reg(upx_pkg::REG_HEIGHT, 2);
    idle_on      = 1'b0;
    hold_off_req = 1'b1;
    repeat (60) send_item(make_item(10));
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    idle_on = 1'b1;
    run_random_phase(2, 3, 2, 25, 8);
    idle_on = 1'b0;
    run_random_phase(0, 5, 3, 25, 8);
    idle_on = 1'b1;
    run_random_phase(3, 0, 4, 25, 8);
    run_random_phase(4, 7, 0, 25, 8);
    run_random_phase(1, 13, 5, 25, 8);
    // scale register all ones clamps to the maximum factor
    idle_on = 1'b0;
    run_random_phase(127, 1, 2, 25, 4);
    idle_on = 1'b1;
    run_random_phase(5, 9, 3, 25, 8);
    repeat (2)
      run_random_phase($urandom_range(1, 8), $urandom_range(1, 24), $urandom_range(1, 4),
                       20, 8);
  endtask

  // Width and height registers all ones clamp to the line buffer and frame limits.
  // Shrink the width afterwards so the long row ends at the next emit.
  task automatic test_widest_row();
    idle_on = 1'b1;
    run_random_phase(1, upx_pkg::DIM_MAX, upx_pkg::DIM_MAX, 1026, 0);
    write_reg(upx_pkg::REG_WIDTH, 1);
    settle_row();
  endtask

  initial begin : rx_side
    int unsigned n;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        n = pick_gap();
        out_ready <= (n == 0);
        repeat ((n == 0) ? $urandom_range(1, 6) : n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    upx_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_data, '0);
      end else begin
        want = expected_pixels_q.pop_front();
        if (out_data.pixel_out !== want.pixel_out)
          report_mismatch("pixel_out", out_data.pixel_out, want.pixel_out);
        if (out_data.pad_bytes !== want.pad_bytes)
          report_mismatch("pad_bytes", out_data.pad_bytes, want.pad_bytes);
        if (out_data.row_end !== want.row_end)
          report_mismatch("row_end", out_data.row_end, want.row_end);
        if (out_data.frame_end !== want.frame_end)
          report_mismatch("frame_end", out_data.frame_end, want.frame_end);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_phase_errors();
    test_midframe_change();
    test_backpressure();
    test_random_traffic();
    test_widest_row();
    drain_block();
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
